/* hdl/assert_macros.svh */
// Assertion macros for the RTL files; stq_back uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

/* hdl/stq_pkg.sv */
// Types and codes shared by the sorted timeout queue modules.
`default_nettype none
package stq_pkg;
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_TIME   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_EXPIRED   = 3'd5;
    localparam logic [2:0] ST_NONE_DUE  = 3'd6;

    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  callback_id;
        logic [15:0] context_id;
        logic [31:0] deadline;
        logic [31:0] now;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  fired_callback;
        logic [15:0] fired_context;
        logic [31:0] fired_deadline;
        logic        last;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EXPIRE
    } t_state;
endpackage
`default_nettype wire

/* hdl/stq_front.sv */
// Request front end: accepts items, drops unused request types, two-entry queue.
`default_nettype none
module stq_front
    import stq_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  wire  i_ready,
    output t_req o_req
);
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_in, w_out;

    assign o_ready = (r_cnt != 2'd2);
    assign w_in    = i_valid && o_ready && (i_req.req_type != REQ_UNUSED);
    assign o_valid = (r_cnt != 2'd0);
    assign w_out   = o_valid && i_ready;
    assign o_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) r_wp <= ~r_wp;
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) r_q[r_wp] <= i_req;
    end
endmodule
`default_nettype wire

/* hdl/stq_back.sv */
// Sorted shift-register table of timeouts and the request sequencer.
`default_nettype none
`include "assert_macros.svh"
module stq_back
    import stq_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  wire  i_ready,
    output t_res o_res
);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);

    logic [7:0]  r_cb [SLOTS];
    logic [15:0] r_ctx [SLOTS];
    logic [31:0] r_dl [SLOTS];
    logic [CW-1:0] r_count;
    t_state r_state, n_state;
    t_req   r_req;
    t_res   r_res;
    logic   r_ovld;
    logic [RW-1:0] r_n;

    logic [SLOTS-1:0] w_match, w_le, w_vld;
    logic w_found, w_full, w_slot_free;
    logic w_take, w_oslot, w_do_exec, w_do_pop, w_due;
    logic w_last_pop;

    // Neighbor views of the cells and the per-cell insert controls.
    logic [SLOTS-1:0] w_sh, w_shp, w_lep, w_lp;
    logic [7:0]  w_ncb [SLOTS];
    logic [15:0] w_nctx [SLOTS];
    logic [31:0] w_ndl [SLOTS];
    logic [7:0]  w_pcb [SLOTS];
    logic [15:0] w_pctx [SLOTS];
    logic [31:0] w_pdl [SLOTS];
    logic [7:0]  w_hcb;
    logic [15:0] w_hctx;
    logic [31:0] w_hdl;

    assign w_oslot = !r_ovld || i_ready;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_vld[i]   = (CW'(i) < r_count);
            w_match[i] = w_vld[i] && r_cb[i] == r_req.callback_id
                         && r_ctx[i] == r_req.context_id;
        end
    end
    assign w_found = |w_match;
    assign w_full  = (r_count == CW'(SLOTS));

    // Compute entries that stay ahead of the new one, before removing any match.
    logic [SLOTS-1:0] w_before;
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_before[i] = w_vld[i] && (r_dl[i] <= r_req.deadline);
        end
    end
    assign w_le = w_before;
    assign w_slot_free = w_found || !w_full;

    // w_sh: the matching entry sits at or below the cell, so the cell closes up.
    // w_lep: post-removal entry at this position stays ahead of the new one.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_sh[i] = |(w_match & ((SLOTS'(2) << i) - SLOTS'(1)));
        end
        for (int i = 0; i < SLOTS - 1; i++) begin
            w_lep[i] = w_sh[i] ? w_le[i+1] : w_le[i];
        end
        w_lep[SLOTS-1] = w_sh[SLOTS-1] ? 1'b0 : w_le[SLOTS-1];
    end
    assign w_lp  = {w_lep[SLOTS-2:0], 1'b1};
    assign w_shp = {w_sh[SLOTS-2:0], 1'b0};

    always_comb begin
        for (int i = 0; i < SLOTS - 1; i++) begin
            w_ncb[i]  = r_cb[i+1];
            w_nctx[i] = r_ctx[i+1];
            w_ndl[i]  = r_dl[i+1];
        end
        w_ncb[SLOTS-1]  = r_cb[SLOTS-1];
        w_nctx[SLOTS-1] = r_ctx[SLOTS-1];
        w_ndl[SLOTS-1]  = r_dl[SLOTS-1];
        w_pcb[0]  = '0;
        w_pctx[0] = '0;
        w_pdl[0]  = '0;
        for (int i = 1; i < SLOTS; i++) begin
            w_pcb[i]  = r_cb[i-1];
            w_pctx[i] = r_ctx[i-1];
            w_pdl[i]  = r_dl[i-1];
        end
    end

    // Fields of the matching entry, keys are unique.
    always_comb begin
        w_hcb  = '0;
        w_hctx = '0;
        w_hdl  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (w_match[i]) begin
                w_hcb  = r_cb[i];
                w_hctx = r_ctx[i];
                w_hdl  = r_dl[i];
            end
        end
    end

    assign w_due = (r_count != '0) && (r_dl[0] <= r_req.now);
    assign w_last_pop = (r_n == RW'(MAX_RESULTS - 1)) || !((r_count > CW'(1))
                        && (r_dl[1] <= r_req.now));

    assign o_ready = (r_state == S_IDLE);
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_take) n_state = S_EXEC;
            S_EXEC:   if (w_oslot) n_state = (r_req.req_type == REQ_TIME && w_due
                                              && !w_last_pop) ? S_EXPIRE : S_IDLE;
            S_EXPIRE: if (w_oslot && w_last_pop) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_do_exec = (r_state == S_EXEC) && w_oslot;
        w_do_pop  = w_oslot && ((r_state == S_EXPIRE) ||
                    (w_do_exec && r_req.req_type == REQ_TIME && w_due));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_count <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            if (w_do_pop || w_do_exec) r_ovld <= 1'b1;
            else if (i_ready) r_ovld <= 1'b0;
            if (w_take) r_n <= '0;
            if (w_do_pop) begin
                r_count <= r_count - CW'(1);
                r_n     <= r_n + RW'(1);
            end else if (w_do_exec) begin
                case (r_req.req_type)
                    REQ_ADD:    if (!w_found && !w_full) r_count <= r_count + CW'(1);
                    REQ_CANCEL: if (w_found) r_count <= r_count - CW'(1);
                    default:    r_count <= r_count;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_req <= i_req;
        if (w_do_pop) begin
            r_res <= '{ST_EXPIRED, r_cb[0], r_ctx[0], r_dl[0], w_last_pop};
            for (int i = 0; i < SLOTS - 1; i++) begin
                r_cb[i]  <= r_cb[i+1];
                r_ctx[i] <= r_ctx[i+1];
                r_dl[i]  <= r_dl[i+1];
            end
        end else if (w_do_exec) begin
            case (r_req.req_type)
                REQ_ADD: begin
                    if (!w_slot_free) begin
                        r_res <= '{ST_FULL, r_req.callback_id, r_req.context_id,
                                   r_req.deadline, 1'b1};
                    end else begin
                        r_res <= '{w_found ? ST_REPLACED : ST_ADDED, r_req.callback_id,
                                   r_req.context_id, r_req.deadline, 1'b1};
                        // Each cell: keep its post-removal entry, take the new one at
                        // its rank, or take the entry that sits one below.
                        for (int i = 0; i < SLOTS; i++) begin
                            if (w_lep[i]) begin
                                if (w_sh[i]) begin
                                    r_cb[i]  <= w_ncb[i];
                                    r_ctx[i] <= w_nctx[i];
                                    r_dl[i]  <= w_ndl[i];
                                end
                            end else if (w_lp[i]) begin
                                r_cb[i]  <= r_req.callback_id;
                                r_ctx[i] <= r_req.context_id;
                                r_dl[i]  <= r_req.deadline;
                            end else if (!w_shp[i]) begin
                                r_cb[i]  <= w_pcb[i];
                                r_ctx[i] <= w_pctx[i];
                                r_dl[i]  <= w_pdl[i];
                            end
                        end
                    end
                end
                REQ_CANCEL: begin
                    if (w_found) begin
                        r_res <= '{ST_CANCELLED, w_hcb, w_hctx, w_hdl, 1'b1};
                    end else begin
                        r_res <= '{ST_NOT_FOUND, r_req.callback_id, r_req.context_id,
                                   32'd0, 1'b1};
                    end
                    for (int i = 0; i < SLOTS - 1; i++) begin
                        if (w_sh[i]) begin
                            r_cb[i]  <= r_cb[i+1];
                            r_ctx[i] <= r_ctx[i+1];
                            r_dl[i]  <= r_dl[i+1];
                        end
                    end
                end
                default: r_res <= '{ST_NONE_DUE, 8'd0, 16'd0, 32'd0, 1'b1};
            endcase
        end
    end

    assign o_valid = r_ovld;
    assign o_res   = r_res;

    `ASSERT_CLK(a_count_range, i_clk, i_rst_n, r_count <= CW'(SLOTS), "count overflow")
    `ASSERT_IMP(a_key_unique, i_clk, i_rst_n, r_state == S_EXEC, $onehot0(w_match),
                "duplicate key in table")
    `ASSERT_IMP(a_hold, i_clk, i_rst_n, r_ovld && !i_ready, ##1 $stable(r_res),
                "result changed while stalled")
endmodule
`default_nettype wire

/* hdl/sorted_timeout_queue.sv */
// Top level of the sorted timeout queue.
// Keeps up to TIMER_SLOTS timeouts sorted by deadline in a row of shift-register
// cells. A front queue of two items takes requests while the table engine works;
// request type 3 is dropped there without a result. The engine takes one item from
// the queue when idle and carries it out once the output register is free (compare
// and shift in all cells at once); it takes no new item before the last is done.
// Add, cancel and a time request with nothing due give one result each; a time
// request with k due entries (k up to 16) pops one entry per cycle while the output
// is free, earliest first. An item passes the front queue and the request register;
// its result waits in the output register while m_axis_tready is low and the engine
// waits with it; the input stalls once the front queue holds two items.
// s_axis_tuser bits, low first: req_type[1:0].
// s_axis_tdata bits, low first: callback_id[7:0], context_id[23:8],
// deadline[55:24], now[87:56].
// m_axis_tuser bits, low first: status[2:0].
// m_axis_tdata bits, low first: fired_callback[7:0], fired_context[23:8],
// fired_deadline[55:24]; tlast is last.
`default_nettype none
module sorted_timeout_queue
    import stq_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [87:0] s_axis_tdata,   // callback_id, context_id, deadline, now
    input  wire  [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,   // fired_callback, fired_context, fired_deadline
    output logic [2:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);
    t_req w_in, w_q;
    t_res w_res;
    logic w_qv, w_qr;

    assign w_in.req_type    = s_axis_tuser;
    assign w_in.callback_id = s_axis_tdata[7:0];
    assign w_in.context_id  = s_axis_tdata[23:8];
    assign w_in.deadline    = s_axis_tdata[55:24];
    assign w_in.now         = s_axis_tdata[87:56];

    stq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_req(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_req(w_q)
    );

    stq_back #(.SLOTS(TIMER_SLOTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_req(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {w_res.fired_deadline, w_res.fired_context,
                           w_res.fired_callback};
    assign m_axis_tuser = w_res.status;
    assign m_axis_tlast = w_res.last;
endmodule
`default_nettype wire
